// ===== rtl/fjoc_pkg.sv =====
// Package: phase and status codes, character constants and result type of the JSON object checker.
`default_nettype none
package fjoc_pkg;

  // Parser phase codes; codes 12 to 15 are unused and behave as idle
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_OPENED     = 4'd1,
    PH_KEY        = 4'd2,
    PH_KEY_ESC    = 4'd3,
    PH_KEY_HEX    = 4'd4,
    PH_AFTER_KEY  = 4'd5,
    PH_BEFORE_VAL = 4'd6,
    PH_VAL        = 4'd7,
    PH_VAL_ESC    = 4'd8,
    PH_VAL_HEX    = 4'd9,
    PH_AFTER_VAL  = 4'd10,
    PH_BEFORE_KEY = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_IDLE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ROLE_NONE   = 2'd0,
    ROLE_KEY    = 2'd1,
    ROLE_VALUE  = 2'd2,
    ROLE_STRUCT = 2'd3
  } role_e;

  localparam int unsigned HexW = 3;
  localparam logic [HexW-1:0] HexDigits = 3'd4;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;

  // One result word
  typedef struct packed {
    status_e parse_status;
    logic    pair_done;
    logic    key_done;
    role_e   byte_role;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_esc_letter(input logic [7:0] c);
    is_esc_letter = (c == ChQuote) || (c == ChBslash) || (c == ChSlash) ||
                    (c == ChB) || (c == ChN) || (c == ChR) || (c == ChT);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fjoc_step.sv =====
// Transition logic: next parser phase, hex count and result for one byte.
`default_nettype none
module fjoc_step (
  input  var fjoc_pkg::phase_e          phase_i,
  input  var logic [fjoc_pkg::HexW-1:0] hex_left_i,
  input  var logic [7:0]                text_byte_i,
  input  var logic                      first_byte_i,
  output fjoc_pkg::phase_e              phase_o,
  output logic [fjoc_pkg::HexW-1:0]     hex_left_o,
  output fjoc_pkg::result_t             result_o
);

  logic                      in_val;
  fjoc_pkg::phase_e          base;
  fjoc_pkg::role_e           crole;
  logic                      err;
  logic [fjoc_pkg::HexW-1:0] hex_dec;
  fjoc_pkg::phase_e          ph;
  logic [fjoc_pkg::HexW-1:0] hex;
  fjoc_pkg::result_t         res;

  assign in_val = (phase_i == fjoc_pkg::PH_VAL) || (phase_i == fjoc_pkg::PH_VAL_ESC) ||
                  (phase_i == fjoc_pkg::PH_VAL_HEX);
  assign base   = in_val ? fjoc_pkg::PH_VAL : fjoc_pkg::PH_KEY;
  assign crole  = in_val ? fjoc_pkg::ROLE_VALUE : fjoc_pkg::ROLE_KEY;
  assign hex_dec = (hex_left_i != '0) ? hex_left_i - 1'b1 : hex_left_i;

  // Decode the byte against the current phase
  always_comb begin
    ph  = phase_i;
    hex = hex_left_i;
    err = 1'b0;
    res = '{parse_status: fjoc_pkg::ST_BUSY, pair_done: 1'b0, key_done: 1'b0,
            byte_role: fjoc_pkg::ROLE_NONE};
    if (first_byte_i) begin
      if (text_byte_i == fjoc_pkg::ChLBrace) begin
        res.byte_role = fjoc_pkg::ROLE_STRUCT;
        ph  = fjoc_pkg::PH_OPENED;
        hex = '0;
      end else begin
        err = 1'b1;
      end
    end else begin
      case (phase_i)
        fjoc_pkg::PH_KEY, fjoc_pkg::PH_VAL: begin
          if (text_byte_i == fjoc_pkg::ChQuote) begin
            res.byte_role = fjoc_pkg::ROLE_STRUCT;
            if (in_val) begin
              res.pair_done = 1'b1;
              ph = fjoc_pkg::PH_AFTER_VAL;
            end else begin
              res.key_done = 1'b1;
              ph = fjoc_pkg::PH_AFTER_KEY;
            end
          end else if (text_byte_i < fjoc_pkg::ChSpace) begin
            err = 1'b1;
          end else begin
            res.byte_role = crole;
            if (text_byte_i == fjoc_pkg::ChBslash) begin
              ph = in_val ? fjoc_pkg::PH_VAL_ESC : fjoc_pkg::PH_KEY_ESC;
            end
          end
        end
        fjoc_pkg::PH_KEY_ESC, fjoc_pkg::PH_VAL_ESC: begin
          if (fjoc_pkg::is_esc_letter(text_byte_i)) begin
            res.byte_role = crole;
            ph = base;
          end else if (text_byte_i == fjoc_pkg::ChU) begin
            res.byte_role = crole;
            hex = fjoc_pkg::HexDigits;
            ph  = in_val ? fjoc_pkg::PH_VAL_HEX : fjoc_pkg::PH_KEY_HEX;
          end else begin
            err = 1'b1;
          end
        end
        fjoc_pkg::PH_KEY_HEX, fjoc_pkg::PH_VAL_HEX: begin
          if (fjoc_pkg::is_hex(text_byte_i)) begin
            res.byte_role = crole;
            hex = hex_dec;
            if (hex_dec == '0) begin
              ph = base;
            end
          end else begin
            err = 1'b1;
          end
        end
        fjoc_pkg::PH_OPENED: begin
          if (fjoc_pkg::is_ws(text_byte_i)) begin
            res.byte_role = fjoc_pkg::ROLE_NONE;
          end else if (text_byte_i == fjoc_pkg::ChRBrace) begin
            res.byte_role    = fjoc_pkg::ROLE_STRUCT;
            res.parse_status = fjoc_pkg::ST_DONE;
            ph = fjoc_pkg::PH_IDLE;
          end else if (text_byte_i == fjoc_pkg::ChQuote) begin
            res.byte_role = fjoc_pkg::ROLE_STRUCT;
            ph = fjoc_pkg::PH_KEY;
          end else begin
            err = 1'b1;
          end
        end
        fjoc_pkg::PH_BEFORE_KEY: begin
          if (fjoc_pkg::is_ws(text_byte_i)) begin
            res.byte_role = fjoc_pkg::ROLE_NONE;
          end else if (text_byte_i == fjoc_pkg::ChQuote) begin
            res.byte_role = fjoc_pkg::ROLE_STRUCT;
            ph = fjoc_pkg::PH_KEY;
          end else begin
            err = 1'b1;
          end
        end
        fjoc_pkg::PH_AFTER_KEY: begin
          if (fjoc_pkg::is_ws(text_byte_i)) begin
            res.byte_role = fjoc_pkg::ROLE_NONE;
          end else if (text_byte_i == fjoc_pkg::ChColon) begin
            res.byte_role = fjoc_pkg::ROLE_STRUCT;
            ph = fjoc_pkg::PH_BEFORE_VAL;
          end else begin
            err = 1'b1;
          end
        end
        fjoc_pkg::PH_BEFORE_VAL: begin
          if (fjoc_pkg::is_ws(text_byte_i)) begin
            res.byte_role = fjoc_pkg::ROLE_NONE;
          end else if (text_byte_i == fjoc_pkg::ChQuote) begin
            res.byte_role = fjoc_pkg::ROLE_STRUCT;
            ph = fjoc_pkg::PH_VAL;
          end else begin
            err = 1'b1;
          end
        end
        fjoc_pkg::PH_AFTER_VAL: begin
          if (fjoc_pkg::is_ws(text_byte_i)) begin
            res.byte_role = fjoc_pkg::ROLE_NONE;
          end else if (text_byte_i == fjoc_pkg::ChComma) begin
            res.byte_role = fjoc_pkg::ROLE_STRUCT;
            ph = fjoc_pkg::PH_BEFORE_KEY;
          end else if (text_byte_i == fjoc_pkg::ChRBrace) begin
            res.byte_role    = fjoc_pkg::ROLE_STRUCT;
            res.parse_status = fjoc_pkg::ST_DONE;
            ph = fjoc_pkg::PH_IDLE;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          // Idle and unused codes: ignore the byte until a restart
          res.parse_status = fjoc_pkg::ST_IDLE;
          ph = fjoc_pkg::PH_IDLE;
        end
      endcase
    end
    // Drop everything on a syntax error and go idle
    if (err) begin
      res = '{parse_status: fjoc_pkg::ST_ERR, pair_done: 1'b0, key_done: 1'b0,
              byte_role: fjoc_pkg::ROLE_NONE};
      ph  = fjoc_pkg::PH_IDLE;
      hex = '0;
    end
  end

  assign phase_o    = ph;
  assign hex_left_o = hex;
  assign result_o   = res;

endmodule
`default_nettype wire

// ===== rtl/flat_json_object_checker_top.sv =====
// Top level: input register, parser state and result register of the JSON object checker.
// Use: stream a JSON document in one byte per word on the s_axis channel; tdata carries
// the byte and tuser flags the first byte of a document, which must be an opening brace.
// For every input word one result word leaves on the m_axis channel giving the byte's
// role (whitespace, key content, value content, structural), key-end and pair-end marks,
// and a status: in progress, object complete, syntax error, or idle.
// The parse step runs from the input register straight into the result register: a word
// is held in the input register and moves into the result register once that slot is free.
// Throughput: one word per cycle while m_axis takes every result; the only loop is the phase
// and hex-count register fed back through the combinational parse step.
// After a completed object or an error the parser is idle and reports idle status for
// every byte until a word with tuser set arrives.
// Reset puts the parser idle and empties both registers.
// When m_axis stalls the result is held; the input register still takes one word, and
// then s_axis_tready falls until the result is taken.
`default_nettype none
module flat_json_object_checker_top (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       s_axis_tvalid,
  output logic           s_axis_tready,
  input  var logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  var logic       s_axis_tuser,   // [0] first_byte
  output logic           m_axis_tvalid,
  input  var logic       m_axis_tready,
  output logic [7:0]     m_axis_tdata    // [1:0] byte_role, [2] key_done, [3] pair_done,
                                         // [5:4] parse_status, [7:6] zero
);

  logic                      in_vld_q;
  logic [7:0]                byte_q;
  logic                      first_q;
  logic                      out_vld_q;
  fjoc_pkg::result_t         out_q;
  fjoc_pkg::phase_e          phase_q;
  fjoc_pkg::phase_e          phase_d;
  logic [fjoc_pkg::HexW-1:0] hex_q;
  logic [fjoc_pkg::HexW-1:0] hex_d;
  fjoc_pkg::result_t         res_d;
  logic                      advance;

  // Move the held word into the result register when that slot is free
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  fjoc_step u_step (
    .phase_i      (phase_q),
    .hex_left_i   (hex_q),
    .text_byte_i  (byte_q),
    .first_byte_i (first_q),
    .phase_o      (phase_d),
    .hex_left_o   (hex_d),
    .result_o     (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      byte_q  <= s_axis_tdata;
      first_q <= s_axis_tuser;
    end
  end

  // Parser state advances with each word that is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= fjoc_pkg::PH_IDLE;
      hex_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q <= phase_d;
        hex_q   <= hex_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule
`default_nettype wire

// ===== tb/tb_flat_json_object_checker_top.sv =====
// Testbench: streams JSON byte words through the object checker and compares every result word.
`timescale 1ns / 100ps
module tb_flat_json_object_checker_top;
  import fjoc_pkg::*;

  localparam int unsigned QuietLimit  = 2000;  // cycles with no word moving on either side
  localparam int unsigned DrainCycles = 4;     // two-stage pipeline plus margin
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off

  localparam logic [7:0] WsChars [4]  = '{ChSpace, ChTab, ChCr, ChLf};
  localparam logic [7:0] EscChars [7] = '{ChQuote, ChBslash, ChSlash, ChB, ChN, ChR, ChT};

  // One input word: raw byte and the restart flag
  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
  } word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] text_byte
  logic       s_axis_tuser;   // [0] first_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [1:0] byte_role, [2] key_done, [3] pair_done,
                              // [5:4] parse_status, [7:6] zero

  // Predicted parser state
  phase_e          parser_phase_q = PH_IDLE;
  logic [HexW-1:0] hex_left_q     = '0;

  result_t     pending_results[$];
  word_t       doc_q[$];
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left     = 0;
  result_t     want;
  result_t     got;

  flat_json_object_checker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Character classes
  function automatic logic ws_char(input logic [7:0] c);
    case (c)
      ChSpace, ChTab, ChCr, ChLf: ws_char = 1'b1;
      default: ws_char = 1'b0;
    endcase
  endfunction

  function automatic logic hex_char(input logic [7:0] c);
    hex_char = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic esc_char(input logic [7:0] c);
    case (c)
      ChQuote, ChBslash, ChSlash, ChB, ChN, ChR, ChT: esc_char = 1'b1;
      default: esc_char = 1'b0;
    endcase
  endfunction

  // Advance the predicted parser by one byte and return the result word it yields
  function automatic result_t parse_byte(input logic [7:0] c, input logic first);
    result_t res;
    phase_e  ph;
    phase_e  str_ph;
    phase_e  esc_ph;
    phase_e  hex_ph;
    role_e   text_role;
    logic    in_val;
    logic    bad;
    res = '0;
    res.byte_role = ROLE_NONE;
    res.parse_status = ST_BUSY;
    ph = parser_phase_q;
    bad = 1'b0;
    in_val = (ph == PH_VAL) || (ph == PH_VAL_ESC) || (ph == PH_VAL_HEX);
    if (in_val) begin
      str_ph = PH_VAL;
      esc_ph = PH_VAL_ESC;
      hex_ph = PH_VAL_HEX;
      text_role = ROLE_VALUE;
    end else begin
      str_ph = PH_KEY;
      esc_ph = PH_KEY_ESC;
      hex_ph = PH_KEY_HEX;
      text_role = ROLE_KEY;
    end
    if (first) begin
      if (c == ChLBrace) begin
        res.byte_role = ROLE_STRUCT;
        ph = PH_OPENED;
        hex_left_q = '0;
      end else begin
        bad = 1'b1;
      end
    end else begin
      case (ph)
        PH_KEY, PH_VAL: begin
          if (c == ChQuote) begin
            res.byte_role = ROLE_STRUCT;
            if (in_val) begin
              res.pair_done = 1'b1;
              ph = PH_AFTER_VAL;
            end else begin
              res.key_done = 1'b1;
              ph = PH_AFTER_KEY;
            end
          end else if (c < ChSpace) begin
            bad = 1'b1;
          end else begin
            res.byte_role = text_role;
            if (c == ChBslash) ph = esc_ph;
          end
        end
        PH_KEY_ESC, PH_VAL_ESC: begin
          if (esc_char(c)) begin
            res.byte_role = text_role;
            ph = str_ph;
          end else if (c == ChU) begin
            res.byte_role = text_role;
            hex_left_q = HexDigits;
            ph = hex_ph;
          end else begin
            bad = 1'b1;
          end
        end
        PH_KEY_HEX, PH_VAL_HEX: begin
          if (hex_char(c)) begin
            res.byte_role = text_role;
            if (hex_left_q != '0) hex_left_q = hex_left_q - 1'b1;
            if (hex_left_q == '0) ph = str_ph;
          end else begin
            bad = 1'b1;
          end
        end
        PH_OPENED: begin
          if (!ws_char(c)) begin
            if (c == ChRBrace) begin
              res.byte_role = ROLE_STRUCT;
              res.parse_status = ST_DONE;
              ph = PH_IDLE;
            end else if (c == ChQuote) begin
              res.byte_role = ROLE_STRUCT;
              ph = PH_KEY;
            end else begin
              bad = 1'b1;
            end
          end
        end
        PH_BEFORE_KEY: begin
          if (!ws_char(c)) begin
            if (c == ChQuote) begin
              res.byte_role = ROLE_STRUCT;
              ph = PH_KEY;
            end else begin
              bad = 1'b1;
            end
          end
        end
        PH_AFTER_KEY: begin
          if (!ws_char(c)) begin
            if (c == ChColon) begin
              res.byte_role = ROLE_STRUCT;
              ph = PH_BEFORE_VAL;
            end else begin
              bad = 1'b1;
            end
          end
        end
        PH_BEFORE_VAL: begin
          if (!ws_char(c)) begin
            if (c == ChQuote) begin
              res.byte_role = ROLE_STRUCT;
              ph = PH_VAL;
            end else begin
              bad = 1'b1;
            end
          end
        end
        PH_AFTER_VAL: begin
          if (!ws_char(c)) begin
            if (c == ChComma) begin
              res.byte_role = ROLE_STRUCT;
              ph = PH_BEFORE_KEY;
            end else if (c == ChRBrace) begin
              res.byte_role = ROLE_STRUCT;
              res.parse_status = ST_DONE;
              ph = PH_IDLE;
            end else begin
              bad = 1'b1;
            end
          end
        end
        default: begin
          res.parse_status = ST_IDLE;
          ph = PH_IDLE;
        end
      endcase
    end
    // Drop back to idle on any syntax error
    if (bad) begin
      res = '0;
      res.byte_role = ROLE_NONE;
      res.parse_status = ST_ERR;
      ph = PH_IDLE;
      hex_left_q = '0;
    end
    parser_phase_q = ph;
    return res;
  endfunction

  // Document building
  function automatic void push_word(input logic [7:0] c, input logic first);
    word_t w;
    w.text_byte = c;
    w.first_byte = first;
    doc_q.push_back(w);
  endfunction

  function automatic void push_gap();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) push_word(WsChars[$urandom_range(0, 3)], 1'b0);
  endfunction

  function automatic void push_string();
    string       hex_set;
    int unsigned len;
    logic [7:0]  c;
    hex_set = "0123456789abcdefABCDEF";
    len = $urandom_range(0, 5);
    push_word(ChQuote, 1'b0);
    repeat (len) begin
      case ($urandom_range(0, 5))
        0: push_word(8'h80 + $urandom_range(0, 127), 1'b0);
        1: begin
          push_word(ChBslash, 1'b0);
          push_word(EscChars[$urandom_range(0, 6)], 1'b0);
        end
        2: begin
          push_word(ChBslash, 1'b0);
          push_word(ChU, 1'b0);
          repeat (4) push_word(hex_set[$urandom_range(0, 21)], 1'b0);
        end
        default: begin
          do c = $urandom_range(32, 126); while (c == ChQuote || c == ChBslash);
          push_word(c, 1'b0);
        end
      endcase
    end
    push_word(ChQuote, 1'b0);
  endfunction

  function automatic void build_document();
    int unsigned members;
    members = $urandom_range(0, 3);
    push_word(ChLBrace, 1'b1);
    push_gap();
    for (int m = 0; m < members; m++) begin
      if (m > 0) begin
        push_word(ChComma, 1'b0);
        push_gap();
      end
      push_string();
      push_gap();
      push_word(ChColon, 1'b0);
      push_gap();
      push_string();
      push_gap();
    end
    push_word(ChRBrace, 1'b0);
  endfunction

  // Offer one word, hold it until taken, then record its expected result
  task automatic send_word(input word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = w.text_byte;
    s_axis_tuser = w.first_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(parse_byte(w.text_byte, w.first_byte));
    @(negedge clk_i);
  endtask

  task automatic send_queued();
    while (doc_q.size() != 0) send_word(doc_q.pop_front());
  endtask

  // Hold the sender until every result word has come back
  task automatic wait_for_results();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Random documents, some damaged, with stray words between them
  task automatic send_documents(input int unsigned word_budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned pos;
    word_t       comma_w;
    sent = 0;
    comma_w.text_byte = ChComma;
    comma_w.first_byte = 1'b0;
    while (sent < word_budget) begin
      build_document();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        pos = $urandom_range(1, doc_q.size() - 1);
        doc_q[pos].text_byte = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) doc_q[pos].first_byte = 1'b1;
      end else if (pick < 28) begin
        pos = $urandom_range(1, doc_q.size() - 1);
        while (doc_q.size() > pos) void'(doc_q.pop_back());
      end else if (pick < 32) begin
        doc_q.insert(doc_q.size() - 1, comma_w);
      end
      sent += doc_q.size();
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3))
          push_word($urandom_range(0, 255), $urandom_range(0, 7) == 0);
      end
      send_queued();
    end
    wait_for_results();
  endtask

  task automatic test_idle_and_restart();
    push_word(8'h00, 1'b0);      // idle after reset
    push_word(8'hFF, 1'b1);      // restart on a byte that is not a brace
    push_word(ChLBrace, 1'b1);
    push_word(ChQuote, 1'b0);
    push_word(ChLBrace, 1'b1);   // restart in the middle of a key
    send_queued();
    wait_for_results();
  endtask

  task automatic test_escapes();
    push_word(ChLBrace, 1'b1);
    push_word(ChQuote, 1'b0);
    push_word(ChBslash, 1'b0);
    push_word(ChU, 1'b0);
    push_word("F", 1'b0);
    push_word("a", 1'b0);
    push_word("0", 1'b0);
    push_word("9", 1'b0);
    push_word(ChQuote, 1'b0);
    push_word(ChTab, 1'b0);
    push_word(ChColon, 1'b0);
    push_word(ChQuote, 1'b0);
    push_word(8'hFF, 1'b0);      // high byte is ordinary value content
    push_word(ChBslash, 1'b0);
    push_word("x", 1'b0);        // bad escape letter
    send_queued();
    wait_for_results();
  endtask

  task automatic test_empty_members();
    push_word(ChLBrace, 1'b1);
    push_word(ChQuote, 1'b0);
    push_word(ChQuote, 1'b0);
    push_word(ChColon, 1'b0);
    push_word(ChQuote, 1'b0);
    push_word(ChQuote, 1'b0);
    push_word(ChComma, 1'b0);
    push_word(ChRBrace, 1'b0);   // closing brace straight after a comma
    send_queued();
    wait_for_results();
  endtask

  task automatic test_streaming_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_documents(470);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 77;
    recv_stall_pct = 0;
    send_documents(470);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 77;
    send_documents(470);
  endtask

  task automatic test_mixed_idle();
    send_idle_pct = 38;
    recv_stall_pct = 38;
    send_documents(470);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_left = HoldCycles;
    @(negedge clk_i);
    send_documents(60);
  endtask

  // Receiver: random stalls, or a counted hold-off when requested
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word %h arrived with none expected", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        got = result_t'(m_axis_tdata[5:0]);
        check_field("byte_role", want.byte_role, got.byte_role);
        check_field("key_done", want.key_done, got.key_done);
        check_field("pair_done", want.pair_done, got.pair_done);
        check_field("parse_status", want.parse_status, got.parse_status);
        check_field("padding", 0, m_axis_tdata[7:6]);
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_and_restart();
    test_escapes();
    test_empty_members();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    test_backpressure();

    wait_for_results();
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== flat_json_object_checker_top.f =====
rtl/fjoc_pkg.sv
rtl/fjoc_step.sv
rtl/flat_json_object_checker_top.sv
tb/tb_flat_json_object_checker_top.sv
